/* design/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg - shared types for the binary min-heap priority queue
// Request and response payloads, status and mode codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 7;
    localparam int STS_W = 2;

    // operation codes
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic signed [KEY_W-1:0] min_key;
        logic [STS_W-1:0]        status;
        logic [OCC_W-1:0]        occupancy;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_L,
        S_DN_LCMP,
        S_DN_RCMP,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

/* design/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue - priority queue on an array-backed binary min-heap
// Insert sifts the new key up, extract returns the root and sifts the last
// key down from the root. One request at a time, one response per request.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload (bmhq_pkg)
//  ----------+-------------------------+-----------------------------------
//  request   | i_in_valid / o_in_ready | i_in_data  : t_req (mode, key)
//  response  | o_out_valid/ i_out_ready| o_out_data : t_rsp (min_key,
//            |                         |              status, occupancy)
//
//  The single memory read port and the shared key comparator pace both
//  sifts: each key looked at on a level needs its own read and its own
//  compare.
//  Full insert and empty extract skip the sift and go straight to the response.
//  Reset clears the count, the output valid and the sequencer; the key store needs no clearing.
//  A response that is not taken holds in the output register; the next
//  request is still accepted and runs until its own response is due.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire bmhq_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output bmhq_pkg::t_rsp      o_out_data
);

    import bmhq_pkg::*;

    // index width, count width, and a child index width with headroom
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    t_state r_state, n_state;

    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_pos, n_pos;
    logic signed [KEY_W-1:0] r_cur, n_cur;        // key being sifted
    logic signed [KEY_W-1:0] r_best_key, n_best_key;
    logic                   r_best_left, n_best_left;
    logic signed [KEY_W-1:0] r_min, n_min;
    logic [STS_W-1:0]       r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_out_data, n_out_data;

    // memory port
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [KEY_W-1:0]       mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [KEY_W-1:0]       mem_rdata;
    logic signed [KEY_W-1:0] rd_key;

    // shared comparator
    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic                   cmp_lt;

    // heap index arithmetic
    logic [IW-1:0]          lidx, ridx, cnt_ext;
    logic                   l_ok, r_ok;
    logic [AW-1:0]          parent;
    logic                   accept, rsp_free;

    bmhq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_key     = $signed(mem_rdata);
    assign lidx       = {1'b0, r_pos, 1'b1};
    assign ridx       = lidx + IW'(1);
    assign cnt_ext    = IW'(r_count);
    assign l_ok       = (lidx < cnt_ext);
    assign r_ok       = (ridx < cnt_ext);
    assign parent     = AW'((r_pos - AW'(1)) >> 1);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign rsp_free   = !r_out_valid || i_out_ready;

    // One signed compare serves every step: sift-up asks "new key below its
    // parent", sift-down asks "child below the best so far".
    always_comb begin
        cmp_a = rd_key;
        cmp_b = r_cur;
        case (r_state)
            S_UP_CMP: begin
                cmp_a = r_cur;
                cmp_b = rd_key;
            end
            S_DN_RCMP: begin
                cmp_a = rd_key;
                cmp_b = r_best_key;
            end
            default: begin
                cmp_a = rd_key;
                cmp_b = r_cur;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.mode == MODE_INSERT) begin
                        n_state = (r_count == CW'(CAPACITY)) ? S_RESP : S_UP_CHK;
                    end else begin
                        n_state = (r_count == '0) ? S_RESP : S_EX_ROOT;
                    end
                end
            end
            S_UP_CHK:  n_state = (r_pos == '0) ? S_RESP : S_UP_CMP;
            S_UP_CMP:  n_state = cmp_lt ? S_UP_CHK : S_RESP;
            S_EX_ROOT: n_state = S_EX_LAST;
            S_EX_LAST: n_state = S_DN_L;
            S_DN_L:    n_state = l_ok ? S_DN_LCMP : S_RESP;
            S_DN_LCMP: begin
                if (r_ok) begin
                    n_state = S_DN_RCMP;
                end else begin
                    n_state = cmp_lt ? S_DN_L : S_RESP;
                end
            end
            S_DN_RCMP: n_state = (cmp_lt || r_best_left) ? S_DN_L : S_RESP;
            S_RESP:    n_state = rsp_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_best_key  = r_best_key;
        n_best_left = r_best_left;
        n_min       = r_min;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_cur;
        mem_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_min    = '0;
                    n_status = STS_OK;
                    if (i_in_data.mode == MODE_INSERT) begin
                        // drop the key when the heap is full
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STS_FULL;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_cur   = i_in_data.key;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            mem_raddr = '0;
                            n_count   = r_count - CW'(1);
                        end
                    end
                end
            end
            S_UP_CHK: begin
                // root reached: park the key here
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_raddr = parent;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (cmp_lt) begin
                    // move the parent down, keep climbing
                    mem_wdata = rd_key;
                    n_pos     = parent;
                end
            end
            S_EX_ROOT: begin
                n_min     = rd_key;
                mem_raddr = AW'(r_count);   // last held entry
            end
            S_EX_LAST: begin
                n_cur = rd_key;
                n_pos = '0;
            end
            S_DN_L: begin
                if (l_ok) begin
                    mem_raddr = AW'(lidx);
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_DN_LCMP: begin
                n_best_left = cmp_lt;
                n_best_key  = cmp_lt ? rd_key : r_cur;
                if (r_ok) begin
                    mem_raddr = AW'(ridx);
                end else begin
                    mem_we = 1'b1;
                    if (cmp_lt) begin
                        mem_wdata = rd_key;
                        n_pos     = AW'(lidx);
                    end
                end
            end
            S_DN_RCMP: begin
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wdata = rd_key;
                    n_pos     = AW'(ridx);
                end else if (r_best_left) begin
                    mem_wdata = r_best_key;
                    n_pos     = AW'(lidx);
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (rsp_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.min_key   = r_min;
                    n_out_data.status    = r_status;
                    n_out_data.occupancy = OCC_W'(r_count);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_cur       <= n_cur;
        r_best_key  <= n_best_key;
        r_best_left <= n_best_left;
        r_min       <= n_min;
        r_status    <= n_status;
        r_out_data  <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* design/bmhq_ram.sv */
// ----------------------------------------------------------------------------
// bmhq_ram - heap key storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
